[src/crc32ts_pkg.sv]
// Package for the CRC-32 suffix trimmer: widths, stage record, GF(2) operator types.
// Builds the constant per-length-bit inverse zero-shift operators at elaboration.
// No dependencies.
package crc32ts_pkg;

  localparam int CRC_DIM  = 32;
  localparam int LEN_BITS = 31;
  localparam logic [CRC_DIM-1:0] INV_POLY = 32'hdb710641;

  typedef logic [CRC_DIM-1:0]  crc_t;
  typedef logic [LEN_BITS-1:0] len_t;

  // column i holds the image of bit i
  typedef logic [CRC_DIM-1:0][CRC_DIM-1:0] op_t;
  typedef op_t [LEN_BITS-1:0]              op_tab_t;

  // one word as it moves down the cell chain
  typedef struct packed {
    logic valid;
    crc_t crc;
    len_t len;
  } stage_t;

  // multiply a GF(2) matrix by a vector
  function automatic crc_t op_apply(input op_t m, input crc_t v);
    crc_t acc;
    acc = '0;
    for (int i = 0; i < CRC_DIM; i++) begin
      if (v[i]) begin
        acc = acc ^ m[i];
      end
    end
    return acc;
  endfunction

  function automatic op_t op_square(input op_t m);
    op_t r;
    for (int i = 0; i < CRC_DIM; i++) begin
      r[i] = op_apply(m, m[i]);
    end
    return r;
  endfunction

  // entry k is the inverse shift by 2^k zero bytes
  function automatic op_tab_t build_ops();
    op_tab_t tab;
    op_t     op;
    for (int i = 0; i < CRC_DIM - 1; i++) begin
      op[i] = crc_t'(1) << (i + 1);
    end
    op[CRC_DIM-1] = INV_POLY;
    // one bit -> two -> four -> one byte
    op = op_square(op);
    op = op_square(op);
    op = op_square(op);
    tab[0] = op;
    for (int k = 1; k < LEN_BITS; k++) begin
      tab[k] = op_square(tab[k-1]);
    end
    return tab;
  endfunction

  localparam op_tab_t OP_TABLE = build_ops();

endpackage

[src/crc32ts_req_if.sv]
// Request channel of the CRC-32 suffix trimmer: valid/ready plus input word.
// Depends on crc32ts_pkg.
interface crc32ts_req_if;
  logic                  valid;
  logic                  ready;
  crc32ts_pkg::crc_t     crc_whole;
  crc32ts_pkg::crc_t     crc_suffix;
  crc32ts_pkg::len_t     suffix_bytes;

  modport source (output valid, crc_whole, crc_suffix, suffix_bytes, input ready);
  modport sink   (input valid, crc_whole, crc_suffix, suffix_bytes, output ready);
endinterface

[src/crc32ts_rsp_if.sv]
// Response channel of the CRC-32 suffix trimmer: valid/ready plus result word.
// Depends on crc32ts_pkg.
interface crc32ts_rsp_if;
  logic              valid;
  logic              ready;
  crc32ts_pkg::crc_t crc_prefix;

  modport source (output valid, crc_prefix, input ready);
  modport sink   (input valid, crc_prefix, output ready);
endinterface

[src/crc32ts_cell.sv]
// One cell of the trimming chain: applies its constant operator when the low
// length bit is set, then hands the word and the shifted length on. Uses crc32ts_pkg.
module crc32ts_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  crc32ts_pkg::op_t    op,
  input  crc32ts_pkg::stage_t d,
  output crc32ts_pkg::stage_t q
);

  crc32ts_pkg::crc_t crc_next;

  // conditional operator application for this length bit
  always_comb begin
    crc_next = d.len[0] ? crc32ts_pkg::op_apply(op, d.crc) : d.crc;
  end

  // valid bit is the only control state; payload is not reset
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= d.valid;
    end
    if (en) begin
      q.crc <= crc_next;
      q.len <= d.len >> 1;
    end
  end

endmodule

[src/crc32_trim_suffix_top.sv]
// CRC-32 suffix trimmer: one cell per length bit, each applying a constant operator.
// Each accepted word is registered through the chain of LEN_BITS (31) cells to the result.
// Throughput: one word per cycle; the whole chain holds while a result waits.
// Reset clears the valid bits of all cells; payload is not reset.
// Depends on crc32ts_pkg, crc32ts_req_if, crc32ts_rsp_if, crc32ts_cell.
module crc32_trim_suffix_top (
  input logic           clk,
  input logic           rst,
  crc32ts_req_if.sink   req,
  crc32ts_rsp_if.source rsp
);

  crc32ts_pkg::stage_t chain [crc32ts_pkg::LEN_BITS+1];
  logic                en;

  // chain advances unless the last cell holds an untaken result
  assign en        = !(chain[crc32ts_pkg::LEN_BITS].valid && !rsp.ready);
  assign req.ready = en;

  // entry: zero length passes crc_whole through untouched
  assign chain[0].valid = req.valid;
  assign chain[0].len   = req.suffix_bytes;
  assign chain[0].crc   = (req.suffix_bytes == '0) ? req.crc_whole
                                                   : (req.crc_whole ^ req.crc_suffix);

  // one cell per length bit
  for (genvar k = 0; k < crc32ts_pkg::LEN_BITS; k++) begin : g_cell
    crc32ts_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .op  (crc32ts_pkg::OP_TABLE[k]),
      .d   (chain[k]),
      .q   (chain[k+1])
    );
  end

  assign rsp.valid      = chain[crc32ts_pkg::LEN_BITS].valid;
  assign rsp.crc_prefix = chain[crc32ts_pkg::LEN_BITS].crc;

endmodule

[src/crc32ts_chk.sv]
// Port-level checks for the CRC-32 suffix trimmer, bound to the top level.
// Depends on crc32ts_pkg and crc32_trim_suffix_top.
module crc32ts_chk (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input crc32ts_pkg::crc_t rsp_crc_prefix
);

  // a waiting result holds its word
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_crc_prefix))
    else $error("result dropped or changed while stalled");

  // input side stalls exactly when a result waits
  a_ready: assert property (@(posedge clk) disable iff (rst)
    req_ready == !(rsp_valid && !rsp_ready))
    else $error("request ready does not track output stall");

  // nothing comes out right after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

  // a stalled output takes no new word
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !(req_valid && req_ready))
    else $error("word accepted while output stalled");

endmodule

bind crc32_trim_suffix_top crc32ts_chk u_chk (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_crc_prefix (rsp.crc_prefix)
);
